// ===== sv/bbs_pkg.sv =====
// ---------------------------------------------------------------------------
// bbs_pkg - shared types and constants for the bouncing ball step block
// Register map, command and status types, reset values, velocity saturation.
// ---------------------------------------------------------------------------
package bbs_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_W   = 20;
  localparam int VEL_W   = 24;
  localparam int Q16_W   = 16;
  localparam int SIZE_W  = 12;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int VSUM_W  = 34;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

  // multiplier operand and product widths
  localparam int MA_W = VEL_W + 1;
  localparam int MB_W = Q16_W + 1;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic signed [VSUM_W-1:0] VEL_MAX_S = VSUM_W'(34'sd8388607);
  localparam logic signed [VSUM_W-1:0] VEL_MIN_S = -VSUM_W'(34'sd8388608);

  localparam logic [Q16_W-1:0]  GRAVITY_RST     = 16'd500;
  localparam logic [Q16_W-1:0]  DRAG_RST        = 16'd6554;
  localparam logic [Q16_W-1:0]  RESTITUTION_RST = 16'd32768;
  localparam logic [SIZE_W-1:0] DIAMETER_RST    = 12'd40;
  localparam logic [SIZE_W-1:0] AREA_WIDTH_RST  = 12'd800;
  localparam logic [SIZE_W-1:0] AREA_HEIGHT_RST = 12'd600;

  typedef enum logic [CIDX_W-1:0] {
    CFG_GRAVITY     = 3'd0,
    CFG_DRAG        = 3'd1,
    CFG_RESTITUTION = 3'd2,
    CFG_DIAMETER    = 3'd3,
    CFG_AREA_WIDTH  = 3'd4,
    CFG_AREA_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [Q16_W-1:0]  gravity;
    logic [Q16_W-1:0]  drag;
    logic [Q16_W-1:0]  restitution;
    logic [SIZE_W-1:0] diameter;
    logic [SIZE_W-1:0] area_width;
    logic [SIZE_W-1:0] area_height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K,
    ST_G,
    ST_DX,
    ST_DY,
    ST_MX,
    ST_MY,
    ST_BX,
    ST_BY,
    ST_RY,
    ST_WB
  } state_t;

  // datapath step: most steps consume the last product and issue the next
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_K,
    STEP_G,
    STEP_DX,
    STEP_DY,
    STEP_MX,
    STEP_MY,
    STEP_BX,
    STEP_BY,
    STEP_RY
  } step_t;

  typedef struct packed {
    logic  start_tick;
    logic  start_load;
    step_t step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VSUM_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > VEL_MAX_S) begin
      r = VEL_MAX_S[VEL_W-1:0];
    end else if (v < VEL_MIN_S) begin
      r = VEL_MIN_S[VEL_W-1:0];
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/bbs_cfg.sv =====
// ---------------------------------------------------------------------------
// bbs_cfg - configuration registers
// Six registers written by index; indexes past the map are dropped.
// ---------------------------------------------------------------------------
module bbs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bbs_pkg::CDATA_W-1:0] cfg_data,
  output bbs_pkg::cfg_t               cfg
);
  import bbs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity     <= GRAVITY_RST;
      cfg_r.drag        <= DRAG_RST;
      cfg_r.restitution <= RESTITUTION_RST;
      cfg_r.diameter    <= DIAMETER_RST;
      cfg_r.area_width  <= AREA_WIDTH_RST;
      cfg_r.area_height <= AREA_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRAVITY:     cfg_r.gravity     <= cfg_data;
        CFG_DRAG:        cfg_r.drag        <= cfg_data;
        CFG_RESTITUTION: cfg_r.restitution <= cfg_data;
        CFG_DIAMETER:    cfg_r.diameter    <= cfg_data[SIZE_W-1:0];
        CFG_AREA_WIDTH:  cfg_r.area_width  <= cfg_data[SIZE_W-1:0];
        CFG_AREA_HEIGHT: cfg_r.area_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// bbs_ctrl - sequencer
// Walks a tick through the multiply steps, sends a load straight to write-back,
// and hands the result to the output register once it is free.
// ---------------------------------------------------------------------------
module bbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           mode,
  input  bbs_pkg::stat_t stat,
  output bbs_pkg::cmd_t  cmd
);
  import bbs_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = mode ? ST_WB : ST_K;
        end
      end
      ST_K:  state_nxt = ST_G;
      ST_G:  state_nxt = ST_DX;
      ST_DX: state_nxt = ST_DY;
      ST_DY: state_nxt = ST_MX;
      ST_MX: state_nxt = ST_MY;
      ST_MY: state_nxt = ST_BX;
      ST_BX: state_nxt = ST_BY;
      ST_BY: state_nxt = ST_RY;
      ST_RY: state_nxt = ST_WB;
      ST_WB: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.start_tick = accept && !mode;
    cmd.start_load = accept && mode;
    cmd.out_load   = (state_r == ST_WB) && !stat.out_busy;
    unique case (state_r)
      ST_K:    cmd.step = STEP_K;
      ST_G:    cmd.step = STEP_G;
      ST_DX:   cmd.step = STEP_DX;
      ST_DY:   cmd.step = STEP_DY;
      ST_MX:   cmd.step = STEP_MX;
      ST_MY:   cmd.step = STEP_MY;
      ST_BX:   cmd.step = STEP_BX;
      ST_BY:   cmd.step = STEP_BY;
      ST_RY:   cmd.step = STEP_RY;
      default: cmd.step = STEP_NONE;
    endcase
  end

endmodule

// ===== sv/bbs_dp.sv =====
// ---------------------------------------------------------------------------
// bbs_dp - ball state datapath
// One shared registered 25x17 multiplier, velocity and position update,
// wall clamp and the output register.
// ---------------------------------------------------------------------------
module bbs_dp #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bbs_pkg::cfg_t                  cfg,
  input  bbs_pkg::cmd_t                  cmd,
  output bbs_pkg::stat_t                 stat,
  input  logic [bbs_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bbs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser
);
  import bbs_pkg::*;

  // wide enough for position plus move, and for the window limit in fixed point
  localparam int LIM_W  = SIZE_W + FRAC_BITS + 1;
  localparam int WIDE_W = ((LIM_W > 26) ? LIM_W : 26) + 1;
  localparam int GSH    = Q16_W - FRAC_BITS;

  logic [Q16_W-1:0]              dt_r;
  logic [Q16_W-1:0]              k_r;
  logic [POS_W-1:0]              pos_x_r, pos_y_r;
  logic signed [VEL_W-1:0]       vel_x_r, vel_y_r;
  logic signed [WIDE_W-1:0]      pw_r;
  logic                          hx_r, hy_r;
  logic signed [MP_W-1:0]        prod_r;
  logic [OUT_DATA_W-1:0]         out_data_r;
  logic [1:0]                    out_user_r;
  logic                          out_valid_r;

  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [25:0]            prod_hi;
  logic [31:0]                   grav_term;
  logic signed [VEL_W-1:0]       vy_grav;
  logic signed [VEL_W-1:0]       v_sel;
  logic signed [VEL_W-1:0]       v_drag;
  logic [POS_W-1:0]              pos_sel;
  logic signed [WIDE_W-1:0]      pw_move;
  logic [SIZE_W-1:0]             size_sel;
  logic signed [WIDE_W-1:0]      dia_w, lim_w, cl_w;
  logic                          hit;
  logic [POS_W-1:0]              clamp_pos;
  logic signed [MP_W:0]          neg_prod;
  logic signed [VEL_W-1:0]       reb;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      STEP_K: begin
        mul_a = $signed({{(MA_W-Q16_W){1'b0}}, cfg.drag});
        mul_b = $signed({1'b0, dt_r});
      end
      STEP_G: begin
        mul_a = $signed({{(MA_W-Q16_W){1'b0}}, cfg.gravity});
        mul_b = $signed({1'b0, dt_r});
      end
      STEP_DX: begin
        mul_a = {vel_x_r[VEL_W-1], vel_x_r};
        mul_b = $signed({1'b0, k_r});
      end
      STEP_DY: begin
        mul_a = {vel_y_r[VEL_W-1], vel_y_r};
        mul_b = $signed({1'b0, k_r});
      end
      STEP_MX: begin
        mul_a = {vel_x_r[VEL_W-1], vel_x_r};
        mul_b = $signed({1'b0, dt_r});
      end
      STEP_MY: begin
        mul_a = {vel_y_r[VEL_W-1], vel_y_r};
        mul_b = $signed({1'b0, dt_r});
      end
      STEP_BX: begin
        mul_a = {vel_x_r[VEL_W-1], vel_x_r};
        mul_b = $signed({1'b0, cfg.restitution});
      end
      STEP_BY: begin
        mul_a = {vel_y_r[VEL_W-1], vel_y_r};
        mul_b = $signed({1'b0, cfg.restitution});
      end
      default: ;
    endcase
  end

  // arithmetic shift of the product rounds toward minus infinity
  assign prod_hi   = prod_r[MP_W-1:16];
  assign grav_term = prod_r[31:0] >> GSH;
  assign vy_grav   = sat_vel($signed({{(VSUM_W-VEL_W){vel_y_r[VEL_W-1]}}, vel_y_r})
                             + $signed({2'b00, grav_term}));

  assign v_sel  = (cmd.step == STEP_DY) ? vel_x_r : vel_y_r;
  assign v_drag = sat_vel($signed({{(VSUM_W-VEL_W){v_sel[VEL_W-1]}}, v_sel})
                          - $signed({{(VSUM_W-26){prod_hi[25]}}, prod_hi}));

  assign pos_sel = (cmd.step == STEP_MY) ? pos_x_r : pos_y_r;
  assign pw_move = $signed({{(WIDE_W-POS_W){1'b0}}, pos_sel})
                   + $signed({{(WIDE_W-26){prod_hi[25]}}, prod_hi});

  // wall clamp on the held position
  assign size_sel = (cmd.step == STEP_BX) ? cfg.area_width : cfg.area_height;
  assign dia_w    = $signed({{(WIDE_W-SIZE_W){1'b0}}, cfg.diameter}) <<< FRAC_BITS;
  assign lim_w    = $signed({{(WIDE_W-SIZE_W){1'b0}}, size_sel}) <<< FRAC_BITS;

  always_comb begin
    priority if (pw_r + dia_w >= lim_w) begin
      hit  = 1'b1;
      cl_w = lim_w - dia_w;
      if (cl_w < 0) begin
        cl_w = '0;
      end
    end else if (pw_r <= 0) begin
      hit  = 1'b1;
      cl_w = '0;
    end else begin
      hit  = 1'b0;
      cl_w = pw_r;
    end
    if (cl_w > $signed({{(WIDE_W-POS_W){1'b0}}, POS_MAX})) begin
      clamp_pos = POS_MAX;
    end else begin
      clamp_pos = cl_w[POS_W-1:0];
    end
  end

  assign neg_prod = -$signed({prod_r[MP_W-1], prod_r});
  assign reb      = sat_vel($signed({{(VSUM_W-(MP_W-15)){neg_prod[MP_W]}},
                                     neg_prod[MP_W:16]}));

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      hx_r    <= 1'b0;
      hy_r    <= 1'b0;
    end else begin
      if (cmd.start_load) begin
        pos_x_r <= in_tdata[35:16];
        pos_y_r <= in_tdata[55:36];
        vel_x_r <= $signed(in_tdata[79:56]);
        vel_y_r <= $signed(in_tdata[103:80]);
        hx_r    <= 1'b0;
        hy_r    <= 1'b0;
      end
      if (cmd.start_tick) begin
        hx_r <= 1'b0;
        hy_r <= 1'b0;
      end
      unique case (cmd.step)
        STEP_DX: vel_y_r <= vy_grav;
        STEP_DY: vel_x_r <= v_drag;
        STEP_MX: vel_y_r <= v_drag;
        STEP_BX: begin
          pos_x_r <= clamp_pos;
          hx_r    <= hit;
        end
        STEP_BY: begin
          if (hx_r) begin
            vel_x_r <= reb;
          end
          pos_y_r <= clamp_pos;
          hy_r    <= hit;
        end
        STEP_RY: begin
          if (hy_r) begin
            vel_y_r <= reb;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers without reset
  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      dt_r <= in_tdata[15:0];
    end
    if (cmd.step == STEP_G) begin
      k_r <= prod_r[31:16];
    end
    if (cmd.step == STEP_MY || cmd.step == STEP_BX) begin
      pw_r <= pw_move;
    end
    if (cmd.out_load) begin
      out_data_r <= {vel_y_r, vel_x_r, pos_y_r, pos_x_r};
      out_user_r <= {hy_r, hx_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_user_r;

endmodule

// ===== sv/bouncing_ball_step.sv =====
// ---------------------------------------------------------------------------
// bouncing_ball_step - one fixed-point Euler step of a bouncing ball
// Holds one ball's position and velocity; a tick word advances it by dt with
// gravity, drag and wall bounce, a load word places it. One result per word.
// ---------------------------------------------------------------------------
// A tick word runs from acceptance through nine steps around one shared
// registered 25x17 multiplier, eight of them issuing a product (drag factor,
// gravity, drag on x and y, move on x and y, rebound on x and y) and the last
// one taking the y rebound, each product feeding the next, then into the
// output register once it is free; in_tready returns after that write-back.
// A load word goes straight to that write-back. The output register holds
// the finished word, so a stalled result only delays the next word's
// write-back, not its acceptance.
module bouncing_ball_step #(
  parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // from bit 0: tick_dt[15:0], load_x[35:16], load_y[55:36],
  // load_vx[79:56], load_vy[103:80]
  input  logic [bbs_pkg::IN_DATA_W-1:0]  in_tdata,
  // bit 0: mode (0 tick, 1 load)
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // from bit 0: out_x[19:0], out_y[39:20], out_vx[63:40], out_vy[87:64]
  output logic [bbs_pkg::OUT_DATA_W-1:0] out_tdata,
  // bit 0: hit_x, bit 1: hit_y
  output logic [1:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbs_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [bbs_pkg::CDATA_W-1:0]    cfg_data
);
  import bbs_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  bbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .mode      (in_tuser[0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/bbs_chk.sv =====
// ---------------------------------------------------------------------------
// bbs_chk - port-level checks for bouncing_ball_step
// Output hold, one word in flight, load echo timing.
// ---------------------------------------------------------------------------
module bbs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [bbs_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [0:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bbs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // only one word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  // a load into an empty output stage is echoed through the write-back state, no hits
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && !out_tvalid |=> ##1
      out_tvalid && out_tuser == 2'b00 &&
      out_tdata[19:0] == $past(in_tdata[35:16], 2) &&
      out_tdata[87:64] == $past(in_tdata[103:80], 2))
    else $error("load word not echoed");

endmodule

bind bouncing_ball_step bbs_chk u_bbs_chk (.*);
